@@ hw/rtl/farc_pkg.sv @@
// ----------------------------------------------------------------------------
// farc_pkg
// Shared types and constants of the fully associative result cache.
// ----------------------------------------------------------------------------
package farc_pkg;

   localparam int LINES   = 16;
   localparam int LINE_W  = $clog2(LINES);
   localparam int COUNT_W = $clog2(LINES + 1);
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = 48;

   localparam int REQ_TDATA_W = ((KEY_W + VALUE_W + 1 + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((LINE_W + VALUE_W + 1 + 2 * CNT_W + 7) / 8) * 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - (KEY_W + VALUE_W + 1);
   localparam int RSP_PAD_W   = RSP_TDATA_W - (LINE_W + VALUE_W + 1 + 2 * CNT_W);

   localparam logic [COUNT_W-1:0] ENTRIES_RESET = COUNT_W'(LINES);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef enum logic {
      ACT_LOOKUP = 1'b0,
      ACT_FILL   = 1'b1
   } action_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/farc_ctrl.sv @@
// ----------------------------------------------------------------------------
// farc_ctrl
// Sequencer: takes a request word, then executes it once the output is free.
// ----------------------------------------------------------------------------
module farc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  farc_pkg::status_type status,
   output farc_pkg::cmd_type    cmd
);
   import farc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.execute = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/farc_datapath.sv @@
// ----------------------------------------------------------------------------
// farc_datapath
// Line store, parallel key compare, FIFO victim pointer, counters and the
// registered response word.
// ----------------------------------------------------------------------------
module farc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tuser,
   input  logic [farc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                csr_wen,
   input  logic [farc_pkg::COUNT_W-1:0]        csr_wdata,
   input  farc_pkg::cmd_type                   cmd,
   output farc_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,
   output logic [farc_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import farc_pkg::*;

   logic [COUNT_W-1:0] entries_ff;

   action_type         action_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               possible_ff;

   logic [KEY_W-1:0]   keys_ff     [LINES];
   logic [VALUE_W-1:0] fitness_ff  [LINES];
   logic               possibles_ff[LINES];
   logic [LINES-1:0]   valid_ff;

   logic [LINE_W-1:0]  victim_ff;
   logic [LINE_W-1:0]  victim_in;
   logic [CNT_W-1:0]   hits_ff;
   logic [CNT_W-1:0]   hits_in;
   logic [CNT_W-1:0]   misses_ff;
   logic [CNT_W-1:0]   misses_in;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic               rsp_hit_in;
   logic [LINE_W-1:0]  rsp_line_ff;
   logic [LINE_W-1:0]  rsp_line_in;
   logic [VALUE_W-1:0] rsp_fitness_ff;
   logic [VALUE_W-1:0] rsp_fitness_in;
   logic               rsp_possible_ff;
   logic               rsp_possible_in;

   logic [COUNT_W-1:0] lines_n;
   logic [LINES-1:0]   match;
   logic               hit_any;
   logic [LINE_W-1:0]  hit_line;
   logic [LINE_W-1:0]  fill_line;
   logic [COUNT_W-1:0] fill_next;
   logic               fill_en;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else if (csr_wen) begin
         entries_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= action_type'(req_tuser);
         key_ff      <= req_tdata[KEY_W-1:0];
         value_ff    <= req_tdata[KEY_W +: VALUE_W];
         possible_ff <= req_tdata[KEY_W + VALUE_W];
      end
   end

   assign lines_n = (entries_ff > COUNT_W'(LINES)) ? COUNT_W'(LINES) : entries_ff;

   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         match[i] = valid_ff[i] && (keys_ff[i] == key_ff) && (COUNT_W'(i) < lines_n);
      end
   end

   assign hit_any = |match;

   always_comb begin
      hit_line = '0;
      for (int i = LINES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_line = LINE_W'(i);
         end
      end
   end

   // pointer left beyond the lines in use restarts at line zero
   assign fill_line = ({1'b0, victim_ff} < lines_n) ? victim_ff : '0;
   assign fill_next = {1'b0, fill_line} + COUNT_W'(1);
   assign fill_en   = cmd.execute && (action_ff == ACT_FILL) && (lines_n != '0);

   always_comb begin
      victim_in       = victim_ff;
      hits_in         = hits_ff;
      misses_in       = misses_ff;
      rsp_hit_in      = 1'b0;
      rsp_line_in     = '0;
      rsp_fitness_in  = '0;
      rsp_possible_in = 1'b0;
      unique case (action_ff)
         ACT_LOOKUP: begin
            if (hit_any) begin
               rsp_hit_in      = 1'b1;
               rsp_line_in     = hit_line;
               rsp_fitness_in  = fitness_ff[hit_line];
               rsp_possible_in = possibles_ff[hit_line];
               hits_in         = hits_ff + CNT_W'(1);
            end else begin
               misses_in = misses_ff + CNT_W'(1);
            end
         end
         ACT_FILL: begin
            if (lines_n != '0) begin
               rsp_line_in = fill_line;
               victim_in   = (fill_next >= lines_n) ? '0 : fill_next[LINE_W-1:0];
            end
         end
         default: begin
            rsp_hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fill_en) begin
         keys_ff[fill_line]      <= key_ff;
         fitness_ff[fill_line]   <= value_ff;
         possibles_ff[fill_line] <= possible_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         victim_ff <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (cmd.execute) begin
         if (fill_en) begin
            valid_ff[fill_line] <= 1'b1;
         end
         victim_ff <= victim_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_hit_ff      <= rsp_hit_in;
         rsp_line_ff     <= rsp_line_in;
         rsp_fitness_ff  <= rsp_fitness_in;
         rsp_possible_ff <= rsp_possible_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, misses_ff, hits_ff, rsp_possible_ff,
                        rsp_fitness_ff, rsp_line_ff};

endmodule

@@ hw/rtl/fully_associative_result_cache.sv @@
// ----------------------------------------------------------------------------
// fully_associative_result_cache
// Sixteen-line fully associative memo cache with FIFO replacement.
// ----------------------------------------------------------------------------
// Request words arrive on req_*: req_tuser selects lookup (0) or fill (1),
// req_tdata carries key, fill fitness and fill possible flag. Every request
// yields one response word on rsp_*: rsp_tuser is the hit flag, rsp_tdata
// carries line, fitness, possible flag and the running hit and miss counts.
// A lookup compares the key with all valid lines in use at once; the lowest
// matching line wins. A fill writes at the round-robin victim pointer.
// csr_wen/csr_wdata set the number of lines in use (0 disables the cache);
// write it only while no request is in flight.
// A request is captured, then executed into the response register once the
// output is free; the two-state capture/execute sequencer takes a new request
// only after the last one has executed. The response register holds a
// finished word while the next request is taken; with the receiver stalled,
// that request waits and req_tready stays low until the held word is accepted.
// Reset clears all valid bits, the victim pointer and both counters at once,
// and sets the lines in use to 16.
// ----------------------------------------------------------------------------
module fully_associative_result_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // action
   // key[63:0], fill_fitness[95:64], fill_possible[96], zero pad
   input  logic [farc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,  // hit
   // line[3:0], fitness[35:4], possible[36], hits_so_far[84:37],
   // misses_so_far[132:85], zero pad
   output logic [farc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wen,
   input  logic [farc_pkg::COUNT_W-1:0]        csr_wdata   // entries_in_use
);
   import farc_pkg::*;

   cmd_type    cmd;
   status_type status;

   farc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   farc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
